@@ design/wpm_pkg.sv @@
// Shared constants and types of the window pooling block.
// Used by every module of the block; depends on nothing.
package wpm_pkg;

  // Default sizing of the line store.
  localparam int MAX_WIN_D      = 8;
  localparam int MAX_COLS_D     = 256;
  localparam int MAX_CHANNELS_D = 16;

  // Data and register widths.
  localparam int DATA_W   = 16;
  localparam int CFG_IW   = 3;
  localparam int CFG_DW   = 11;
  localparam int NUM_REGS = 7;

  // Widths that carry the largest legal parameter values.
  localparam int SLOT_W = 4;
  localparam int COL_W  = 12;
  localparam int CH_W   = 8;
  localparam int WIN_W  = 5;
  localparam int AREA_W = 9;

  // Register indexes.
  localparam logic [CFG_IW-1:0] REG_MODE     = 3'd0;
  localparam logic [CFG_IW-1:0] REG_WIN_ROWS = 3'd1;
  localparam logic [CFG_IW-1:0] REG_WIN_COLS = 3'd2;
  localparam logic [CFG_IW-1:0] REG_STRIDE   = 3'd3;
  localparam logic [CFG_IW-1:0] REG_MAP_ROWS = 3'd4;
  localparam logic [CFG_IW-1:0] REG_MAP_COLS = 3'd5;
  localparam logic [CFG_IW-1:0] REG_CHANNELS = 3'd6;

  // Pool modes.
  localparam logic MODE_MAX = 1'b0;
  localparam logic MODE_AVG = 1'b1;

  // One line store write.
  typedef struct packed {
    logic                     we;
    logic [SLOT_W-1:0]        slot;
    logic [COL_W-1:0]         col;
    logic [CH_W-1:0]          ch;
    logic signed [DATA_W-1:0] data;
  } wr_t;

  // One window job from the front to the back.
  typedef struct packed {
    logic              valid;
    logic [SLOT_W-1:0] slot;
    logic [COL_W-1:0]  left;
    logic [CH_W-1:0]   ch;
    logic [WIN_W-1:0]  rows;
    logic [WIN_W-1:0]  cols;
    logic [AREA_W-1:0] area;
    logic              mode;
    logic              last;
  } job_t;

  // One finished result.
  typedef struct packed {
    logic signed [DATA_W-1:0] pooled;
    logic                     frame_last;
  } res_t;

endpackage

@@ design/wpm_front.sv @@
// Front end: configuration registers, raster counters and window detection.
// Depends on wpm_pkg.
module wpm_front #(
  parameter int MAX_WIN      = wpm_pkg::MAX_WIN_D,
  parameter int MAX_COLS     = wpm_pkg::MAX_COLS_D,
  parameter int MAX_CHANNELS = wpm_pkg::MAX_CHANNELS_D
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [wpm_pkg::CFG_IW-1:0]        cfg_index,
  input  logic [wpm_pkg::CFG_DW-1:0]        cfg_wdata,
  input  logic                              in_push,
  input  logic signed [wpm_pkg::DATA_W-1:0] in_sample,
  output logic                              in_full,
  input  logic                              back_idle,
  output wpm_pkg::wr_t                      wr_o,
  output wpm_pkg::job_t                     job_o
);

  localparam int SW = (MAX_WIN > 1) ? $clog2(MAX_WIN) : 1;
  localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int HW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  logic        mode_r;
  logic [3:0]  win_rows_r, win_cols_r, stride_r;
  logic [10:0] map_rows_r;
  logic [8:0]  map_cols_r;
  logic [4:0]  channels_r;

  logic [9:0]    row_r, row_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [HW-1:0] ch_r, ch_nxt;
  logic [SW-1:0] slot_r, slot_nxt;
  logic [3:0]    rmod_r, rmod_nxt, cmod_r, cmod_nxt;

  logic [4:0]  wr_e, wc_e;
  logic [3:0]  st_e;
  logic [10:0] mr_e;
  logic [12:0] mc_e;
  logic [8:0]  nc_e;

  logic        accept, rok, cok, hit, ch_end, col_end, row_end, last_r_ok, last_c_ok;
  logic        cfg_hit;
  logic [10:0] top;
  logic [12:0] left;
  logic [5:0]  slot0;
  logic [5:0]  wr_m1;

  // Effective sizes: zero acts as one; large window, map and channel sizes are clamped.
  always_comb begin
    wr_e = (win_rows_r == 4'd0) ? 5'd1 :
           ({1'b0, win_rows_r} > 5'(MAX_WIN)) ? 5'(MAX_WIN) : {1'b0, win_rows_r};
    wc_e = (win_cols_r == 4'd0) ? 5'd1 :
           ({1'b0, win_cols_r} > 5'(MAX_WIN)) ? 5'(MAX_WIN) : {1'b0, win_cols_r};
    st_e = (stride_r == 4'd0) ? 4'd1 : stride_r;
    mr_e = (map_rows_r == 11'd0) ? 11'd1 :
           (map_rows_r > 11'd1024) ? 11'd1024 : map_rows_r;
    mc_e = (map_cols_r == 9'd0) ? 13'd1 :
           (13'(map_cols_r) > 13'(MAX_COLS)) ? 13'(MAX_COLS) : 13'(map_cols_r);
    nc_e = (channels_r == 5'd0) ? 9'd1 :
           (9'(channels_r) > 9'(MAX_CHANNELS)) ? 9'(MAX_CHANNELS) : 9'(channels_r);
  end

  assign in_full = !back_idle;
  assign accept  = in_push && !in_full;
  assign cfg_hit = cfg_we && (cfg_index < 3'(wpm_pkg::NUM_REGS));

  // Window detection for the current sample.
  always_comb begin
    rok       = (11'(row_r) + 11'd1) >= 11'(wr_e);
    cok       = (13'(col_r) + 13'd1) >= 13'(wc_e);
    hit       = rok && cok && (rmod_r == 4'd0) && (cmod_r == 4'd0);
    top       = 11'(row_r) + 11'd1 - 11'(wr_e);
    left      = 13'(col_r) + 13'd1 - 13'(wc_e);
    last_r_ok = (12'(top) + 12'(st_e)) > (12'(mr_e) - 12'(wr_e));
    last_c_ok = (14'(left) + 14'(st_e)) > (14'(mc_e) - 14'(wc_e));
    ch_end    = (9'(ch_r) + 9'd1) >= nc_e;
    col_end   = (13'(col_r) + 13'd1) >= mc_e;
    row_end   = (11'(row_r) + 11'd1) >= mr_e;
    wr_m1     = 6'(wr_e) - 6'd1;
    slot0     = (6'(slot_r) >= wr_m1) ? 6'(slot_r) - wr_m1
                                      : 6'(slot_r) + 6'(MAX_WIN) - wr_m1;
  end

  // Raster counter advance.
  always_comb begin
    ch_nxt   = ch_r;
    col_nxt  = col_r;
    row_nxt  = row_r;
    slot_nxt = slot_r;
    rmod_nxt = rmod_r;
    cmod_nxt = cmod_r;
    if (!ch_end) begin
      ch_nxt = ch_r + HW'(1);
    end else begin
      ch_nxt = '0;
      if (!col_end) begin
        col_nxt = col_r + CW'(1);
        if ((13'(col_r) + 13'd2) >= 13'(wc_e)) begin
          cmod_nxt = !cok ? 4'd0 : ((cmod_r + 4'd1) == st_e) ? 4'd0 : cmod_r + 4'd1;
        end
      end else begin
        col_nxt  = '0;
        cmod_nxt = 4'd0;
        if (!row_end) begin
          row_nxt  = row_r + 10'd1;
          slot_nxt = (32'(slot_r) == MAX_WIN - 1) ? '0 : slot_r + SW'(1);
          if ((11'(row_r) + 11'd2) >= 11'(wr_e)) begin
            rmod_nxt = !rok ? 4'd0 : ((rmod_r + 4'd1) == st_e) ? 4'd0 : rmod_r + 4'd1;
          end
        end else begin
          row_nxt  = '0;
          slot_nxt = '0;
          rmod_nxt = 4'd0;
        end
      end
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= wpm_pkg::MODE_MAX;
      win_rows_r <= 4'd2;
      win_cols_r <= 4'd2;
      stride_r   <= 4'd2;
      map_rows_r <= 11'd4;
      map_cols_r <= 9'd4;
      channels_r <= 5'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        wpm_pkg::REG_MODE:     mode_r     <= cfg_wdata[0];
        wpm_pkg::REG_WIN_ROWS: win_rows_r <= cfg_wdata[3:0];
        wpm_pkg::REG_WIN_COLS: win_cols_r <= cfg_wdata[3:0];
        wpm_pkg::REG_STRIDE:   stride_r   <= cfg_wdata[3:0];
        wpm_pkg::REG_MAP_ROWS: map_rows_r <= cfg_wdata[10:0];
        wpm_pkg::REG_MAP_COLS: map_cols_r <= cfg_wdata[8:0];
        wpm_pkg::REG_CHANNELS: channels_r <= cfg_wdata[4:0];
        default: ;
      endcase
    end
  end

  // Raster counters; a register write restarts the image.
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_hit) begin
      row_r  <= '0;
      col_r  <= '0;
      ch_r   <= '0;
      slot_r <= '0;
      rmod_r <= '0;
      cmod_r <= '0;
    end else if (accept) begin
      row_r  <= row_nxt;
      col_r  <= col_nxt;
      ch_r   <= ch_nxt;
      slot_r <= slot_nxt;
      rmod_r <= rmod_nxt;
      cmod_r <= cmod_nxt;
    end
  end

  // Line store write and job hand-off.
  always_comb begin
    wr_o.we   = accept;
    wr_o.slot = wpm_pkg::SLOT_W'(slot_r);
    wr_o.col  = wpm_pkg::COL_W'(col_r);
    wr_o.ch   = wpm_pkg::CH_W'(ch_r);
    wr_o.data = in_sample;

    job_o.valid = accept && hit;
    job_o.slot  = slot0[wpm_pkg::SLOT_W-1:0];
    job_o.left  = left[wpm_pkg::COL_W-1:0];
    job_o.ch    = wpm_pkg::CH_W'(ch_r);
    job_o.rows  = wr_e;
    job_o.cols  = wc_e;
    job_o.area  = wpm_pkg::AREA_W'(10'(wr_e) * 10'(wc_e));
    job_o.mode  = mode_r;
    job_o.last  = last_r_ok && last_c_ok && ((9'(ch_r) + 9'd1) == nc_e);
  end

endmodule

@@ design/wpm_resq.sv @@
// Two-entry result queue in front of the output port.
// Depends on wpm_pkg.
module wpm_resq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  wpm_pkg::res_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output wpm_pkg::res_t pop_data
);

  wpm_pkg::res_t slot_r [2];
  logic       wptr_r, rptr_r;
  logic [1:0] cnt_r;
  logic       do_push, do_pop;

  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slot_r[rptr_r];

  // Storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wptr_r] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (do_push) begin
        wptr_r <= !wptr_r;
      end
      if (do_pop) begin
        rptr_r <= !rptr_r;
      end
      cnt_r <= cnt_r + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

@@ design/wpm_back.sv @@
// Back end: line store, window read-out, maximum and sum, serial divider.
// Depends on wpm_pkg.
module wpm_back #(
  parameter int MAX_WIN      = wpm_pkg::MAX_WIN_D,
  parameter int MAX_COLS     = wpm_pkg::MAX_COLS_D,
  parameter int MAX_CHANNELS = wpm_pkg::MAX_CHANNELS_D
) (
  input  logic          clk,
  input  logic          rst_n,
  input  wpm_pkg::wr_t  wr_i,
  input  wpm_pkg::job_t job_i,
  output logic          idle,
  output logic          res_push,
  output wpm_pkg::res_t res_data,
  input  logic          res_full
);

  localparam int SW    = (MAX_WIN > 1) ? $clog2(MAX_WIN) : 1;
  localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int HW    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int DEPTH = MAX_WIN * MAX_COLS * MAX_CHANNELS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  // The window registers are 4 bits wide, so a side never exceeds 15.
  localparam int WIN_EFF = (MAX_WIN > 15) ? 15 : MAX_WIN;
  localparam int SUM_W = wpm_pkg::DATA_W + $clog2(WIN_EFF * WIN_EFF) + 1;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_READ  = 5'b00010,
    S_DRAIN = 5'b00100,
    S_DIV   = 5'b01000,
    S_PUSH  = 5'b10000
  } state_t;

  state_t state_r;

  logic signed [wpm_pkg::DATA_W-1:0] mem [DEPTH];
  logic signed [wpm_pkg::DATA_W-1:0] rdata_r;
  logic [AW-1:0] waddr, raddr;

  logic [SW-1:0]             slot_r;
  logic [CW-1:0]             left_r;
  logic [HW-1:0]             ch_r;
  logic [wpm_pkg::WIN_W-1:0] rows_r, cols_r, i_r, j_r;
  logic [wpm_pkg::AREA_W-1:0] area_r;
  logic mode_r, last_r, rd_v_r, first_r, neg_r;
  logic signed [SUM_W-1:0]            sum_r, sum_nxt;
  logic signed [wpm_pkg::DATA_W-1:0]  max_r, max_nxt;
  logic [SUM_W-1:0]          divq_r;
  logic [wpm_pkg::AREA_W-1:0] rem_r;
  logic [wpm_pkg::AREA_W:0]   rem_sh;
  logic [4:0]                dcnt_r;
  logic                      issue_last, j_end;
  logic [CW-1:0]             col_rd;
  logic [wpm_pkg::DATA_W-1:0] quo;

  assign idle = (state_r == S_IDLE);

  // Line store addresses.
  always_comb begin
    waddr  = AW'(wr_i.slot[SW-1:0]) * AW'(MAX_COLS * MAX_CHANNELS)
           + AW'(wr_i.col[CW-1:0]) * AW'(MAX_CHANNELS) + AW'(wr_i.ch[HW-1:0]);
    col_rd = left_r + CW'(j_r);
    raddr  = AW'(slot_r) * AW'(MAX_COLS * MAX_CHANNELS)
           + AW'(col_rd) * AW'(MAX_CHANNELS) + AW'(ch_r);
  end

  // Line store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_i.we) begin
      mem[waddr] <= wr_i.data;
    end
    rdata_r <= mem[raddr];
  end

  // Running maximum and sum over the arriving window elements.
  always_comb begin
    sum_nxt = first_r ? SUM_W'(rdata_r) : sum_r + SUM_W'(rdata_r);
    max_nxt = (first_r || (rdata_r > max_r)) ? rdata_r : max_r;
    j_end      = ((j_r + 5'd1) == cols_r);
    issue_last = j_end && ((i_r + 5'd1) == rows_r);
    rem_sh     = {rem_r, divq_r[SUM_W-1]};
    quo        = divq_r[wpm_pkg::DATA_W-1:0];
  end

  // Result presented to the queue.
  always_comb begin
    res_push            = (state_r == S_PUSH);
    res_data.pooled     = (mode_r == wpm_pkg::MODE_AVG) ? (neg_r ? -quo : quo) : max_r;
    res_data.frame_last = last_r;
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      rd_v_r  <= 1'b0;
    end else begin
      rd_v_r <= (state_r == S_READ);
      case (state_r)
        S_IDLE: begin
          if (job_i.valid) begin
            state_r <= S_READ;
          end
        end
        S_READ: begin
          if (issue_last) begin
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state_r <= (mode_r == wpm_pkg::MODE_AVG) ? S_DIV : S_PUSH;
        end
        S_DIV: begin
          if (dcnt_r == 5'd0) begin
            state_r <= S_PUSH;
          end
        end
        S_PUSH: begin
          if (!res_full) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Job registers, read walk, accumulation and division datapath.
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && job_i.valid) begin
      slot_r  <= job_i.slot[SW-1:0];
      left_r  <= job_i.left[CW-1:0];
      ch_r    <= job_i.ch[HW-1:0];
      rows_r  <= job_i.rows;
      cols_r  <= job_i.cols;
      area_r  <= job_i.area;
      mode_r  <= job_i.mode;
      last_r  <= job_i.last;
      i_r     <= '0;
      j_r     <= '0;
      first_r <= 1'b1;
    end
    if (state_r == S_READ && !issue_last) begin
      if (j_end) begin
        j_r    <= '0;
        i_r    <= i_r + 5'd1;
        slot_r <= (32'(slot_r) == MAX_WIN - 1) ? '0 : slot_r + SW'(1);
      end else begin
        j_r <= j_r + 5'd1;
      end
    end
    if (rd_v_r) begin
      sum_r   <= sum_nxt;
      max_r   <= max_nxt;
      first_r <= 1'b0;
    end
    if (state_r == S_DRAIN) begin
      neg_r  <= sum_nxt[SUM_W-1];
      divq_r <= sum_nxt[SUM_W-1] ? SUM_W'(-sum_nxt) : SUM_W'(sum_nxt);
      rem_r  <= '0;
      dcnt_r <= 5'(SUM_W - 1);
    end
    // One quotient bit per cycle, restoring.
    if (state_r == S_DIV) begin
      dcnt_r <= dcnt_r - 5'd1;
      if (rem_sh >= {1'b0, area_r}) begin
        rem_r  <= wpm_pkg::AREA_W'(rem_sh - {1'b0, area_r});
        divq_r <= {divq_r[SUM_W-2:0], 1'b1};
      end else begin
        rem_r  <= rem_sh[wpm_pkg::AREA_W-1:0];
        divq_r <= {divq_r[SUM_W-2:0], 1'b0};
      end
    end
  end

  // A job only arrives while the sequencer is free.
  a_job_idle: assert property (@(posedge clk) disable iff (!rst_n)
    job_i.valid |-> state_r == S_IDLE) else $error("job while back end busy");

  // Read data is only consumed in the cycle after a read was issued.
  a_rd_follows: assert property (@(posedge clk) disable iff (!rst_n)
    rd_v_r |-> $past(state_r == S_READ)) else $error("stray read data");

  // A result waiting on a full queue is held.
  a_push_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PUSH && res_full) |=> state_r == S_PUSH && $stable(res_data))
    else $error("result dropped");

endmodule

@@ design/window_pooling_max_avg_top.sv @@
// Window max/average pooling, one signed 16-bit sample per transaction.
// A sample that completes no window leaves the input free; one that completes
// a window holds the input while the back end reads it from the line store,
// runs a 23-step serial divider in average mode and waits on a full result queue.
// Reset (rst_n, synchronous) restores register defaults and clears counters and
// queues; the line store is not cleared.
module window_pooling_max_avg_top #(
  parameter int MAX_WIN      = wpm_pkg::MAX_WIN_D,
  parameter int MAX_COLS     = wpm_pkg::MAX_COLS_D,
  parameter int MAX_CHANNELS = wpm_pkg::MAX_CHANNELS_D
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [wpm_pkg::CFG_IW-1:0]        cfg_index,
  input  logic [wpm_pkg::CFG_DW-1:0]        cfg_wdata,
  input  logic                              in_push,
  output logic                              in_full,
  input  logic signed [wpm_pkg::DATA_W-1:0] in_sample,
  output logic                              out_empty,
  input  logic                              out_pop,
  output logic signed [wpm_pkg::DATA_W-1:0] out_pooled,
  output logic                              out_frame_last
);

  wpm_pkg::wr_t  wr;
  wpm_pkg::job_t job;
  wpm_pkg::res_t res_in, res_out;
  logic back_idle, res_push, res_full;

  // Counting and window detection.
  wpm_front #(
    .MAX_WIN(MAX_WIN), .MAX_COLS(MAX_COLS), .MAX_CHANNELS(MAX_CHANNELS)
  ) u_front (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_push(in_push), .in_sample(in_sample), .in_full(in_full),
    .back_idle(back_idle), .wr_o(wr), .job_o(job)
  );

  // Window evaluation.
  wpm_back #(
    .MAX_WIN(MAX_WIN), .MAX_COLS(MAX_COLS), .MAX_CHANNELS(MAX_CHANNELS)
  ) u_back (
    .clk(clk), .rst_n(rst_n), .wr_i(wr), .job_i(job), .idle(back_idle),
    .res_push(res_push), .res_data(res_in), .res_full(res_full)
  );

  // Output queue.
  wpm_resq u_resq (
    .clk(clk), .rst_n(rst_n), .push(res_push), .push_data(res_in), .full(res_full),
    .pop(out_pop), .empty(out_empty), .pop_data(res_out)
  );

  assign out_pooled     = res_out.pooled;
  assign out_frame_last = res_out.frame_last;

endmodule
